[src/pmpd_pkg.sv]
package pmpd_pkg;

    localparam logic [15:0] RESYNC_RESET = 16'd51;
    localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_MOTION = 1'b1;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    localparam int FLAG_X_SIGN = 4;
    localparam int FLAG_Y_SIGN = 5;

    typedef struct packed {
        logic [2:0]        changed;
        logic [2:0]        buttons;
        logic              motion;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
    } pkt_desc_t;

endpackage

[src/pmpd_front.sv]
module pmpd_front #(
    parameter int PACKET_BYTES = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [7:0]          data_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                q_full,
    output logic                push,
    output pmpd_pkg::pkt_desc_t push_desc
);
    import pmpd_pkg::*;

    localparam int STORE_N = PACKET_BYTES - 1;
    localparam int IDX_W   = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam logic [1:0] LAST_IDX = 2'(PACKET_BYTES - 1);

    logic [15:0] resync_reg;
    logic [15:0] idle_reg;
    logic [15:0] idle_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [2:0]  prev_reg;
    logic [2:0]  prev_next;
    logic [7:0]  store_reg [STORE_N];

    logic        accept;
    logic        restart;
    logic [1:0]  cnt_eff;
    logic        complete;
    logic        store_we;
    logic [7:0]  flags;
    logic [7:0]  y_byte;
    logic [2:0]  changed;
    logic [8:0]  dx;
    logic [8:0]  dy;
    logic        motion;

    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !q_full;

    assign restart  = (count_reg != 2'd0) && (idle_reg >= resync_reg);
    assign cnt_eff  = restart ? 2'd0 : count_reg;
    assign complete = accept && (mode == MODE_BYTE) && (cnt_eff == LAST_IDX);
    assign store_we = accept && (mode == MODE_BYTE) && (cnt_eff != LAST_IDX);

    generate
        if (STORE_N > 2) begin : g_y_stored
            assign y_byte = store_reg[2];
        end else begin : g_y_live
            assign y_byte = data_byte;
        end
    endgenerate

    assign flags   = store_reg[0];
    assign changed = flags[2:0] ^ prev_reg;
    assign dx      = {flags[FLAG_X_SIGN], store_reg[1]};
    assign dy      = {flags[FLAG_Y_SIGN], y_byte};
    assign motion  = (dx != 9'd0) || (dy != 9'd0);

    assign push              = complete && ((changed != 3'd0) || motion);
    assign push_desc.changed = changed;
    assign push_desc.buttons = flags[2:0];
    assign push_desc.motion  = motion;
    assign push_desc.dx      = dx;
    assign push_desc.dy      = dy;

    always_comb
    begin
        idle_next  = idle_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        if (accept)
        begin
            if (mode == MODE_TICK)
            begin
                if (idle_reg != IDLE_MAX)
                begin
                    idle_next = idle_reg + 16'd1;
                end
            end
            else
            begin
                idle_next = 16'd0;
                if (cnt_eff == LAST_IDX)
                begin
                    count_next = 2'd0;
                    prev_next  = flags[2:0];
                end
                else
                begin
                    count_next = cnt_eff + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resync_reg <= RESYNC_RESET;
            idle_reg   <= 16'd0;
            count_reg  <= 2'd0;
            prev_reg   <= 3'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                resync_reg <= cfg_data;
            end
            idle_reg  <= idle_next;
            count_reg <= count_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[cnt_eff[IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

[src/pmpd_queue.sv]
module pmpd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pmpd_pkg::pkt_desc_t push_desc,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output pmpd_pkg::pkt_desc_t pop_desc
);
    import pmpd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    pkt_desc_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == DEPTH_C);
    assign q_valid  = (cnt_reg != '0);
    assign pop_desc = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_desc;
        end
    end

endmodule

[src/pmpd_back.sv]
module pmpd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  pmpd_pkg::pkt_desc_t pop_desc,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                event_kind,
    output logic [1:0]          button_index,
    output logic                pressed,
    output logic signed [8:0]   delta_x,
    output logic signed [8:0]   delta_y,
    output logic                last_event
);
    import pmpd_pkg::*;

    logic              busy_reg;
    logic [3:0]        pend_reg;
    logic [3:0]        pend_next;
    logic [2:0]        btn_reg;
    logic signed [8:0] dx_reg;
    logic signed [8:0] dy_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [1:0]        idx_reg;
    logic              pressed_reg;
    logic signed [8:0] odx_reg;
    logic signed [8:0] ody_reg;
    logic              last_reg;

    logic              out_free;
    logic              advance;
    logic              done;
    logic              e_kind;
    logic [1:0]        e_idx;
    logic              e_pressed;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = busy_reg && out_free;
    assign done     = advance && (pend_next == 4'd0);
    assign pop      = q_valid && (!busy_reg || done);

    always_comb
    begin
        pend_next = pend_reg;
        e_kind    = KIND_BUTTON;
        e_idx     = BTN_LEFT;
        e_pressed = 1'b0;
        priority if (pend_reg[0])
        begin
            pend_next[0] = 1'b0;
            e_idx        = BTN_LEFT;
            e_pressed    = btn_reg[0];
        end
        else if (pend_reg[1])
        begin
            pend_next[1] = 1'b0;
            e_idx        = BTN_RIGHT;
            e_pressed    = btn_reg[1];
        end
        else if (pend_reg[2])
        begin
            pend_next[2] = 1'b0;
            e_idx        = BTN_MIDDLE;
            e_pressed    = btn_reg[2];
        end
        else
        begin
            pend_next[3] = 1'b0;
            e_kind       = KIND_MOTION;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                pend_reg <= {pop_desc.motion, pop_desc.changed};
            end
            else if (advance)
            begin
                busy_reg <= !done;
                pend_reg <= pend_next;
            end
            if (out_free)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            btn_reg <= pop_desc.buttons;
            dx_reg  <= pop_desc.dx;
            dy_reg  <= pop_desc.dy;
        end
        if (advance)
        begin
            kind_reg    <= e_kind;
            idx_reg     <= e_idx;
            pressed_reg <= e_pressed;
            odx_reg     <= (e_kind == KIND_MOTION) ? dx_reg : 9'sd0;
            ody_reg     <= (e_kind == KIND_MOTION) ? dy_reg : 9'sd0;
            last_reg    <= (pend_next == 4'd0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign button_index = idx_reg;
    assign pressed      = pressed_reg;
    assign delta_x      = odx_reg;
    assign delta_y      = ody_reg;
    assign last_event   = last_reg;

endmodule

[src/ps2_mouse_packet_decoder_top.sv]
// Accepts one item (byte or tick) per cycle while the packet queue has room.
// The first event of a packet passes through the two-entry packet queue, the
// back end's pending register and the output register; a packet's events then
// follow one per cycle while out_stall is low, up to four, from the back end.
// Async active-low reset clears counters, button levels, queue and output valid;
// resync limit resets to 51.
module ps2_mouse_packet_decoder_top #(
    parameter int PACKET_BYTES = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [7:0]        data_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              event_kind,
    output logic [1:0]        button_index,
    output logic              pressed,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              last_event
);
    import pmpd_pkg::*;

    pkt_desc_t push_desc;
    pkt_desc_t pop_desc;
    logic      push;
    logic      q_full;
    logic      pop;
    logic      q_valid;

    pmpd_front #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    pmpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_desc  (pop_desc)
    );

    pmpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .pop_desc     (pop_desc),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .button_index (button_index),
        .pressed      (pressed),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .last_event   (last_event)
    );

endmodule

[src/pmpd_checker.sv]
module pmpd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic              event_kind,
    input logic [1:0]        button_index,
    input logic              pressed,
    input logic signed [8:0] delta_x,
    input logic signed [8:0] delta_y,
    input logic              last_event
);
    import pmpd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({event_kind, button_index, pressed,
                                            delta_x, delta_y, last_event}))
        else $error("stalled request changed");

    a_button_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == KIND_BUTTON) |->
            (delta_x == 9'sd0) && (delta_y == 9'sd0) && (button_index != 2'd3))
        else $error("bad button event");

    a_motion_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == KIND_MOTION) |->
            (button_index == BTN_LEFT) && !pressed && last_event &&
            ((delta_x != 9'sd0) || (delta_y != 9'sd0)))
        else $error("bad motion event");

endmodule

bind ps2_mouse_packet_decoder_top pmpd_checker u_pmpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .button_index (button_index),
    .pressed      (pressed),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .last_event   (last_event)
);

[sim/testbench.sv]
module testbench;
    import pmpd_pkg::*;

    localparam int PACKET_BYTES = 3;
    localparam logic [2:0][1:0] BTN_CODES = {BTN_MIDDLE, BTN_RIGHT, BTN_LEFT};

    typedef struct packed {
        logic              kind;
        logic [1:0]        button;
        logic              down;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic              last_ev;
    } mouse_event_t;

    // n_typed < 0: rely on the decoder model only
    typedef struct packed {
        logic         m;
        logic [7:0]   d;
        int           reps;
        int           n_typed;
        mouse_event_t ev;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [7:0]        data_byte;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [15:0]       cfg_data;
    logic              out_valid;
    logic              out_stall;
    logic              event_kind;
    logic [1:0]        button_index;
    logic              pressed;
    logic signed [8:0] delta_x;
    logic signed [8:0] delta_y;
    logic              last_event;

    // decoder model state
    logic [15:0]  resync_limit = RESYNC_RESET;
    logic [1:0]   pkt_count    = '0;
    logic [7:0]   pkt_bytes [4];
    logic [2:0]   btn_levels   = '0;
    logic [15:0]  tick_count   = '0;
    mouse_event_t new_events [4];
    int           new_count;

    mouse_event_t expected_events [$];

    int send_idle_pct  = 34;
    int recv_stall_pct = 59;
    int mismatch_count = 0;
    int events_checked = 0;
    int motion_checked = 0;
    int bytes_sent     = 0;
    int ticks_sent     = 0;
    int mid_limit;

    stim_row_t directed_rows [24] = '{
        '{MODE_BYTE, 8'h00, 1, 0, '0},
        '{MODE_BYTE, 8'h01, 1, 0, '0},
        '{MODE_BYTE, 8'h00, 1, 1, '{KIND_MOTION, BTN_LEFT, 1'b0, 9'sd1, 9'sd0, 1'b1}},
        '{MODE_BYTE, 8'h07, 1, -1, '0},
        '{MODE_BYTE, 8'h00, 1, -1, '0},
        '{MODE_BYTE, 8'h00, 1, -1, '0},
        '{MODE_BYTE, 8'h30, 1, -1, '0},
        '{MODE_BYTE, 8'h00, 1, -1, '0},
        '{MODE_BYTE, 8'h00, 1, -1, '0},
        '{MODE_BYTE, 8'h00, 1, -1, '0},
        '{MODE_BYTE, 8'hFF, 1, -1, '0},
        '{MODE_BYTE, 8'hFF, 1, 1, '{KIND_MOTION, BTN_LEFT, 1'b0, 9'sd255, 9'sd255, 1'b1}},
        '{MODE_BYTE, 8'hC8, 1, 0, '0},
        '{MODE_BYTE, 8'h00, 1, 0, '0},
        '{MODE_BYTE, 8'h00, 1, 0, '0},
        '{MODE_TICK, 8'hA5, 3, 0, '0},
        '{MODE_BYTE, 8'h02, 1, 0, '0},
        '{MODE_BYTE, 8'h10, 1, 0, '0},
        '{MODE_BYTE, 8'h80, 1, -1, '0},
        '{MODE_BYTE, 8'h04, 1, 0, '0},
        '{MODE_TICK, 8'hFF, 51, 0, '0},
        '{MODE_BYTE, 8'h31, 1, 0, '0},
        '{MODE_BYTE, 8'hFF, 1, 0, '0},
        '{MODE_BYTE, 8'h01, 1, -1, '0}
    };

    ps2_mouse_packet_decoder_top #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .data_byte(data_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .button_index(button_index),
        .pressed(pressed),
        .delta_x(delta_x),
        .delta_y(delta_y),
        .last_event(last_event)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int decode_mouse_item(input logic m, input logic [7:0] d);
        logic [7:0] flags;
        logic [2:0] btns;
        logic [2:0] chg;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        int n;
        n = 0;
        if (m == MODE_TICK)
        begin
            if (tick_count != IDLE_MAX)
                tick_count = tick_count + 16'd1;
            return 0;
        end
        if (pkt_count != 0 && tick_count >= resync_limit)
            pkt_count = '0;
        tick_count = '0;
        pkt_bytes[pkt_count] = d;
        if (int'(pkt_count) + 1 < PACKET_BYTES)
        begin
            pkt_count = pkt_count + 2'd1;
            return 0;
        end
        pkt_count = '0;
        flags = pkt_bytes[0];
        btns = flags[2:0];
        chg = btns ^ btn_levels;
        btn_levels = btns;
        for (int b = 0; b < 3; b++)
        begin
            if (chg[b])
            begin
                new_events[n] = '{KIND_BUTTON, BTN_CODES[b], btns[b], 9'sd0, 9'sd0, 1'b0};
                n++;
            end
        end
        dx = {flags[FLAG_X_SIGN], pkt_bytes[1]};
        dy = {flags[FLAG_Y_SIGN], pkt_bytes[2]};
        if (dx != 0 || dy != 0)
        begin
            new_events[n] = '{KIND_MOTION, BTN_LEFT, 1'b0, dx, dy, 1'b0};
            n++;
        end
        if (n > 0)
            new_events[n - 1].last_ev = 1'b1;
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int exp, input logic bad);
        if (bad)
            report_mismatch($sformatf("event %0d %s: got %0d, expected %0d",
                                      events_checked, name, got, exp));
    endtask

    task automatic compare_mouse_event();
        mouse_event_t got;
        mouse_event_t exp;
        got = '{event_kind, button_index, pressed, delta_x, delta_y, last_event};
        if (expected_events.size() == 0)
        begin
            report_mismatch($sformatf("unexpected event kind %0d btn %0d dx %0d dy %0d",
                                      got.kind, got.button, got.dx, got.dy));
            return;
        end
        exp = expected_events.pop_front();
        check_field("kind", got.kind, exp.kind, got.kind !== exp.kind);
        check_field("button", got.button, exp.button, got.button !== exp.button);
        check_field("pressed", got.down, exp.down, got.down !== exp.down);
        check_field("delta_x", got.dx, exp.dx, got.dx !== exp.dx);
        check_field("delta_y", got.dy, exp.dy, got.dy !== exp.dy);
        check_field("last", got.last_ev, exp.last_ev, got.last_ev !== exp.last_ev);
        events_checked++;
        if (exp.kind == KIND_MOTION)
            motion_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            compare_mouse_event();
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic m, input logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        data_byte = d;
        do
            @(posedge clk);
        while (in_stall);
        new_count = decode_mouse_item(m, d);
        for (int i = 0; i < new_count; i++)
            expected_events.push_back(new_events[i]);
        if (m == MODE_TICK)
            ticks_sent++;
        else
            bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(MODE_TICK, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    task automatic write_resync(input logic [15:0] v);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        resync_limit = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_traffic(input int n_packets);
        logic [7:0] flags;
        int nb;
        int gap;
        for (int i = 0; i < n_packets; i++)
        begin
            if ($urandom_range(99) < 12)
            begin
                if ($urandom_range(1))
                    send_item(MODE_BYTE, 8'($urandom_range(255)));
                else
                    send_ticks($urandom_range(1, 8));
                continue;
            end
            flags = 8'($urandom_range(255));
            if ($urandom_range(3) == 0)
                flags[2:0] = btn_levels;
            nb = ($urandom_range(9) == 0) ? $urandom_range(1, PACKET_BYTES - 1) : PACKET_BYTES;
            for (int k = 0; k < nb; k++)
            begin
                if (k > 0 && $urandom_range(99) < 25)
                begin
                    // land the gap on either side of the resync limit
                    if ($urandom_range(1) && resync_limit <= 200)
                        gap = int'(resync_limit) - 1 + $urandom_range(2);
                    else
                        gap = $urandom_range(1, 4);
                    send_ticks((gap < 1) ? 1 : gap);
                end
                if (k == 0)
                    send_item(MODE_BYTE, flags);
                else
                    send_item(MODE_BYTE, ($urandom_range(4) == 0) ? 8'h00
                                                                  : 8'($urandom_range(255)));
            end
            if (nb < PACKET_BYTES && resync_limit <= 200)
                send_ticks(int'(resync_limit));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_BYTE;
        data_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_data = 16'h0000;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            int got_n;
            got_n = 0;
            repeat (directed_rows[i].reps)
            begin
                send_item(directed_rows[i].m, directed_rows[i].d);
                got_n += new_count;
            end
            if (directed_rows[i].n_typed >= 0)
            begin
                if (got_n != directed_rows[i].n_typed)
                    report_mismatch($sformatf("row %0d: model gives %0d events, table %0d",
                                              i, got_n, directed_rows[i].n_typed));
                else if (got_n == 1 && new_events[0] !== directed_rows[i].ev)
                    report_mismatch($sformatf("row %0d: model event differs from table", i));
            end
        end

        wait_drained();
        write_resync(16'd1);
        random_traffic(4);

        send_idle_pct = 59;
        recv_stall_pct = 34;
        wait_drained();
        write_resync(16'd0);
        random_traffic(3);

        wait_drained();
        mid_limit = int'($urandom_range(2, 8));
        write_resync(16'(mid_limit));
        random_traffic(4);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        write_resync(16'hFFFF);
        random_traffic(3);

        wait_drained();
        $display("Run: %0d bytes, %0d ticks; %0d events checked, %0d of them motion.",
                 bytes_sent, ticks_sent, events_checked, motion_checked);
        $display("Resync limits 51, 1, 0, %0d and 65535, with partial packets and resyncs.",
                 mid_limit);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
src/pmpd_pkg.sv
src/pmpd_front.sv
src/pmpd_queue.sv
src/pmpd_back.sv
src/ps2_mouse_packet_decoder_top.sv
src/pmpd_checker.sv
sim/testbench.sv
